// ===== rtl/core/bsc_pkg.sv =====
// types and constants of the barometric compensation block
// no dependencies
`timescale 1ns / 1ps

package bsc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               divide_error;
  } out_item_t;

  // calibration words as held in the register file
  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [31:0]        ac5_ac6;
    logic [31:0]        b1_b2;
    logic [31:0]        mc_md;
    logic [1:0]         oss;
  } cal_t;

  // register indexes
  localparam logic [2:0] REG_AC1     = 3'd0;
  localparam logic [2:0] REG_AC2     = 3'd1;
  localparam logic [2:0] REG_AC3     = 3'd2;
  localparam logic [2:0] REG_AC4     = 3'd3;
  localparam logic [2:0] REG_AC5_AC6 = 3'd4;
  localparam logic [2:0] REG_B1_B2   = 3'd5;
  localparam logic [2:0] REG_MC_MD   = 3'd6;
  localparam logic [2:0] REG_OSS     = 3'd7;

  // divider geometry
  localparam int T_NUM_W = 27;
  localparam int T_DEN_W = 18;
  localparam int P_NUM_W = 32;
  localparam int P_DEN_W = 17;

  localparam logic signed [31:0] B6_OFS     = 32'sd4000;
  localparam logic [31:0]        B4_OFS     = 32'd32768;
  localparam logic [15:0]        B7_SCALE   = 16'd50000;
  localparam logic signed [31:0] P_C1       = 32'sd3038;
  localparam logic signed [31:0] P_C2       = -32'sd7357;
  localparam logic signed [31:0] P_C3       = 32'sd3791;
  localparam logic signed [31:0] T_MAX      = 32'sd32767;
  localparam logic signed [31:0] T_MIN      = -32'sd32768;
  localparam logic signed [31:0] P_MAX      = 32'sd262143;

  // side data riding through the temperature divider
  typedef struct packed {
    logic signed [16:0] x1;
    logic               neg;
    logic               err;
    logic [18:0]        up;
  } tdiv_pay_t;

  // side data riding through the pressure divider
  typedef struct packed {
    logic signed [15:0] t;
    logic               err;
    logic               hi;
  } pdiv_pay_t;

endpackage

// ===== rtl/core/baro_sensor_compensation_top.sv =====
// top level of the barometric compensation block: calibration registers,
// front stages, two pipelined dividers and the output register
// depends on bsc_pkg, bsc_div_pipe, bsc_mid, bsc_back
`timescale 1ns / 1ps

// usage
// - in_valid/in_stall/in_data carry one request: raw temperature and raw
//   pressure (already shifted right by 8 minus oversampling)
// - out_valid/out_stall/out_data return one result per request, in order:
//   temperature in tenths of a degree, pressure in pascals (saturated) and
//   a divide error flag that zeroes both values
// - cfg_valid/cfg_ready/cfg_index/cfg_data write the calibration words;
//   cfg_ready is always high, write only while no request is in flight
// - throughput: one request per cycle unless the receiver stalls, fully pipelined
// - depth: 69 register stages in all, the two bit-per-stage dividers
//   (27 and 32 stages), 9 arithmetic stages and the output register
// - when the receiver stalls a pending result the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is dropped or repeated
// - reset (rst_n low, synchronous) empties the pipeline and clears all
//   calibration words; a request before ac4 is written reports a divide error

module baro_sensor_compensation_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bsc_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bsc_pkg::out_item_t    out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import bsc_pkg::*;

  cal_t cal_r;

  // global advance: everything moves unless a result is stuck at the port
  logic adv;

  // front stage 1: (ut - ac6) * ac5
  logic signed [16:0] ut_m_ac6;
  logic signed [63:0] m_x1;
  logic               f1_v_r;
  logic signed [31:0] f1_prod_r;
  logic [18:0]        f1_up_r;

  // front stage 2: x1, divisor and dividend magnitudes
  logic signed [16:0] x1;
  logic signed [31:0] den, num, den_abs, num_abs;
  logic signed [15:0] mc, md;
  logic               f2_v_r;
  logic [T_NUM_W-1:0] f2_num_r;
  logic [T_DEN_W-1:0] f2_den_r;
  tdiv_pay_t          f2_pay_r;

  // temperature divider to middle section
  logic               td_v;
  logic [T_NUM_W-1:0] td_quo;
  logic [$bits(tdiv_pay_t)-1:0] td_pay;

  // middle section to pressure divider
  logic               md_v;
  logic [P_NUM_W-1:0] md_num;
  logic [P_DEN_W-1:0] md_den;
  pdiv_pay_t          md_pay;

  logic               pd_v;
  logic [P_NUM_W-1:0] pd_quo;
  logic [$bits(pdiv_pay_t)-1:0] pd_pay;

  logic               bk_v;
  out_item_t          bk_item;

  logic               out_v_r;
  out_item_t          out_r;

  assign adv       = !(out_v_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // calibration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AC1:     cal_r.ac1     <= cfg_data[15:0];
        REG_AC2:     cal_r.ac2     <= cfg_data[15:0];
        REG_AC3:     cal_r.ac3     <= cfg_data[15:0];
        REG_AC4:     cal_r.ac4     <= cfg_data[15:0];
        REG_AC5_AC6: cal_r.ac5_ac6 <= cfg_data;
        REG_B1_B2:   cal_r.b1_b2   <= cfg_data;
        REG_MC_MD:   cal_r.mc_md   <= cfg_data;
        REG_OSS:     cal_r.oss     <= cfg_data[1:0];
        default:     cal_r         <= cal_r;
      endcase
    end
  end

  // uncompensated temperature minus ac6, times ac5, wrapped to 32 bits
  always_comb begin
    ut_m_ac6 = $signed({1'b0, in_data.raw_temperature})
             - $signed({1'b0, cal_r.ac5_ac6[15:0]});
    m_x1     = 64'(ut_m_ac6) * $signed({48'b0, cal_r.ac5_ac6[31:16]});
  end

  // x1 plus md is the temperature divisor, mc * 2048 the dividend
  always_comb begin
    mc      = cal_r.mc_md[31:16];
    md      = cal_r.mc_md[15:0];
    x1      = f1_prod_r[31:15];
    den     = 32'(x1) + 32'(md);
    num     = 32'(mc) <<< 11;
    den_abs = den[31] ? -den : den;
    num_abs = num[31] ? -num : num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r  <= 1'b0;
      f2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r  <= in_valid;
      f2_v_r  <= f1_v_r;
      out_v_r <= bk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_prod_r    <= m_x1[31:0];
      f1_up_r      <= in_data.raw_pressure;
      f2_num_r     <= num_abs[T_NUM_W-1:0];
      f2_den_r     <= den_abs[T_DEN_W-1:0];
      f2_pay_r.x1  <= x1;
      f2_pay_r.neg <= mc[15] ^ den[31];
      f2_pay_r.err <= (den == '0);
      f2_pay_r.up  <= f1_up_r;
      out_r        <= bk_item;
    end
  end

  bsc_div_pipe #(
    .NUM_W (T_NUM_W),
    .DEN_W (T_DEN_W),
    .PAY_W ($bits(tdiv_pay_t))
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f2_v_r),
    .in_num    (f2_num_r),
    .in_den    (f2_den_r),
    .in_pay    (f2_pay_r),
    .out_valid (td_v),
    .out_quo   (td_quo),
    .out_pay   (td_pay)
  );

  bsc_mid u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cal       (cal_r),
    .in_valid  (td_v),
    .in_quo    (td_quo),
    .in_pay    (tdiv_pay_t'(td_pay)),
    .out_valid (md_v),
    .out_num   (md_num),
    .out_den   (md_den),
    .out_pay   (md_pay)
  );

  bsc_div_pipe #(
    .NUM_W (P_NUM_W),
    .DEN_W (P_DEN_W),
    .PAY_W ($bits(pdiv_pay_t))
  ) u_pdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (md_v),
    .in_num    (md_num),
    .in_den    (md_den),
    .in_pay    (md_pay),
    .out_valid (pd_v),
    .out_quo   (pd_quo),
    .out_pay   (pd_pay)
  );

  bsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (pd_v),
    .in_quo    (pd_quo),
    .in_pay    (pdiv_pay_t'(pd_pay)),
    .out_valid (bk_v),
    .out_item  (bk_item)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/bsc_div_pipe.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on nothing but its parameters
`timescale 1ns / 1ps

module bsc_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17,
  parameter int PAY_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quo,
  output logic [PAY_W-1:0] out_pay
);

  logic             v_r   [NUM_W];
  logic [NUM_W-1:0] acc_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [PAY_W-1:0] pay_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             src_v;
    logic [NUM_W-1:0] src_acc;
    logic [DEN_W-1:0] src_rem;
    logic [DEN_W-1:0] src_den;
    logic [PAY_W-1:0] src_pay;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_acc = in_num;
      assign src_rem = '0;
      assign src_den = in_den;
      assign src_pay = in_pay;
    end else begin : g_next
      assign src_v   = v_r[k-1];
      assign src_acc = acc_r[k-1];
      assign src_rem = rem_r[k-1];
      assign src_den = den_r[k-1];
      assign src_pay = pay_r[k-1];
    end

    assign trial = {src_rem, src_acc[NUM_W-1]};
    assign diff  = trial - {1'b0, src_den};
    assign ge    = (trial >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        acc_r[k] <= {src_acc[NUM_W-2:0], ge};
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[k] <= src_den;
        pay_r[k] <= src_pay;
      end
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign out_quo   = acc_r[NUM_W-1];
  assign out_pay   = pay_r[NUM_W-1];

endmodule

// ===== rtl/core/bsc_mid.sv =====
// middle stages: temperature result, b3/b4/b7 terms, pressure divider operands
// depends on bsc_pkg
`timescale 1ns / 1ps

module bsc_mid (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  bsc_pkg::cal_t           cal,
  input  logic                    in_valid,
  input  logic [26:0]             in_quo,
  input  bsc_pkg::tdiv_pay_t      in_pay,
  output logic                    out_valid,
  output logic [31:0]             out_num,
  output logic [16:0]             out_den,
  output bsc_pkg::pdiv_pay_t      out_pay
);
  import bsc_pkg::*;

  logic signed [15:0] b1, b2;

  // stage 1
  logic signed [31:0] x2, b5, t32, b6, tsat;
  logic               v1_r;
  logic signed [15:0] t1_r;
  logic signed [31:0] b6_1_r;
  logic               err1_r;
  logic [18:0]        up1_r;

  // stage 2
  logic signed [63:0] m_sq, m_a2, m_a3;
  logic signed [31:0] sq_w, a2_w, a3_w;
  logic               v2_r;
  logic signed [15:0] t2_r;
  logic               err2_r;
  logic [18:0]        up2_r;
  logic signed [31:0] sq2_r, xa2_r, xc2_r;

  // stage 3
  logic signed [63:0] m_b2, m_b1;
  logic signed [31:0] b2s_w, b1s_w;
  logic               v3_r;
  logic signed [15:0] t3_r;
  logic               err3_r;
  logic [18:0]        up3_r;
  logic signed [31:0] xa3_r, xc3_r, xb3_r, xd3_r;

  // stage 4
  logic signed [31:0] x3a, sum_a, shl_a, b3, x3c;
  logic               v4_r;
  logic signed [15:0] t4_r;
  logic               err4_r;
  logic [18:0]        up4_r;
  logic signed [31:0] b3_4_r;
  logic [31:0]        u4_r;

  // stage 5
  logic [47:0]        m_b4, m_b7;
  logic [31:0]        diff_up;
  logic [15:0]        scale;
  logic               v5_r;
  logic signed [15:0] t5_r;
  logic               err5_r;
  logic [16:0]        b4_5_r;
  logic [31:0]        b7_5_r;

  assign b1 = cal.b1_b2[31:16];
  assign b2 = cal.b1_b2[15:0];

  always_comb begin
    x2   = in_pay.neg ? -$signed({5'b0, in_quo}) : $signed({5'b0, in_quo});
    b5   = 32'(in_pay.x1) + x2;
    t32  = (b5 + 32'sd8) >>> 4;
    b6   = b5 - B6_OFS;
    if (t32 > T_MAX) begin
      tsat = T_MAX;
    end else if (t32 < T_MIN) begin
      tsat = T_MIN;
    end else begin
      tsat = t32;
    end
  end

  always_comb begin
    m_sq = 64'(b6_1_r) * 64'(b6_1_r);
    m_a2 = 64'(cal.ac2) * 64'(b6_1_r);
    m_a3 = 64'(cal.ac3) * 64'(b6_1_r);
    sq_w = m_sq[31:0];
    a2_w = m_a2[31:0];
    a3_w = m_a3[31:0];
  end

  always_comb begin
    m_b2  = 64'(b2) * 64'(sq2_r);
    m_b1  = 64'(b1) * 64'(sq2_r);
    b2s_w = m_b2[31:0];
    b1s_w = m_b1[31:0];
  end

  // b3 and the b4 operand
  always_comb begin
    x3a   = xb3_r + xa3_r;
    sum_a = (32'(cal.ac1) <<< 2) + x3a;
    shl_a = sum_a <<< cal.oss;
    b3    = (shl_a + 32'sd2) >>> 2;
    x3c   = (xc3_r + xd3_r + 32'sd2) >>> 2;
  end

  always_comb begin
    scale   = B7_SCALE >> cal.oss;
    diff_up = {13'b0, up4_r} - b3_4_r;
    m_b4    = {32'b0, cal.ac4} * {16'b0, u4_r};
    m_b7    = {16'b0, diff_up} * {32'b0, scale};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= tsat[15:0];
      b6_1_r <= b6;
      err1_r <= in_pay.err;
      up1_r  <= in_pay.up;

      t2_r   <= t1_r;
      err2_r <= err1_r;
      up2_r  <= up1_r;
      sq2_r  <= sq_w >>> 12;
      xa2_r  <= a2_w >>> 11;
      xc2_r  <= a3_w >>> 13;

      t3_r   <= t2_r;
      err3_r <= err2_r;
      up3_r  <= up2_r;
      xa3_r  <= xa2_r;
      xc3_r  <= xc2_r;
      xb3_r  <= b2s_w >>> 11;
      xd3_r  <= b1s_w >>> 16;

      t4_r   <= t3_r;
      err4_r <= err3_r;
      up4_r  <= up3_r;
      b3_4_r <= b3;
      u4_r   <= x3c + B4_OFS;

      t5_r   <= t4_r;
      err5_r <= err4_r;
      b4_5_r <= m_b4[31:15];
      b7_5_r <= m_b7[31:0];
    end
  end

  // pressure divider operands, top bit of b7 decides the pre-shift
  assign out_valid   = v5_r;
  assign out_den     = b4_5_r;
  assign out_num     = b7_5_r[31] ? b7_5_r : {b7_5_r[30:0], 1'b0};
  assign out_pay.t   = t5_r;
  assign out_pay.err = err5_r | (b4_5_r == '0);
  assign out_pay.hi  = b7_5_r[31];

endmodule

// ===== rtl/core/bsc_back.sv =====
// final stages: pressure correction polynomial and output saturation
// depends on bsc_pkg
`timescale 1ns / 1ps

module bsc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [31:0]             in_quo,
  input  bsc_pkg::pdiv_pay_t      in_pay,
  output logic                    out_valid,
  output bsc_pkg::out_item_t      out_item
);
  import bsc_pkg::*;

  logic [31:0]        q;
  logic signed [31:0] p, ps;
  logic signed [63:0] m_sq, m_np;

  logic               v1_r;
  logic signed [31:0] p1_r, sq1_r, np1_r;
  logic signed [15:0] t1_r;
  logic               err1_r;

  logic signed [63:0] m_c1;
  logic signed [31:0] c1_w;
  logic               v2_r;
  logic signed [31:0] p2_r, x1_2_r, x2_2_r;
  logic signed [15:0] t2_r;
  logic               err2_r;

  logic signed [31:0] corr, pf;
  logic [17:0]        psat;

  always_comb begin
    q    = in_pay.hi ? {in_quo[30:0], 1'b0} : in_quo;
    p    = $signed(q);
    ps   = p >>> 8;
    m_sq = 64'(ps) * 64'(ps);
    m_np = 64'(P_C2) * 64'(p);
  end

  always_comb begin
    m_c1 = 64'(sq1_r) * 64'(P_C1);
    c1_w = m_c1[31:0];
  end

  always_comb begin
    corr = (x1_2_r + x2_2_r + P_C3) >>> 4;
    pf   = p2_r + corr;
    if (pf < 0) begin
      psat = '0;
    end else if (pf > P_MAX) begin
      psat = P_MAX[17:0];
    end else begin
      psat = pf[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= p;
      sq1_r  <= m_sq[31:0];
      np1_r  <= m_np[31:0];
      t1_r   <= in_pay.t;
      err1_r <= in_pay.err;

      p2_r   <= p1_r;
      x1_2_r <= c1_w >>> 16;
      x2_2_r <= np1_r >>> 16;
      t2_r   <= t1_r;
      err2_r <= err1_r;
    end
  end

  assign out_valid                   = v2_r;
  assign out_item.temperature_tenths = err2_r ? '0 : t2_r;
  assign out_item.pressure_pa        = err2_r ? '0 : psat;
  assign out_item.divide_error       = err2_r;

endmodule
